// ===== sv/mfbp_pkg.sv =====
// Package with the constants and types of the MSB-first bit packer.
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int unsigned MaxBits   = 16;
  localparam int unsigned DataW     = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FillW     = 3;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned AccW      = 24;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;
  localparam int unsigned QueueCntW = 3;

  // Saturation limit of bit_count.
  localparam int unsigned CountLimit = (MaxBits < DataW) ? MaxBits : DataW;

  typedef enum logic {
    ReqAppend = 1'b0,
    ReqFinish = 1'b1
  } req_e;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } out_word_t;

endpackage

// ===== sv/msb_first_bit_packer.sv =====
// MSB-first bit packer: packs appended bit runs into bytes and emits a trailer on finish.
//
//  channel  | dir | tdata                                | tuser      | tlast
//  s_axis   | in  | [15:0] data_bits, [20:16] bit_count  | req_type   | -
//  m_axis   | out | [7:0] out_byte                       | -          | is_last
//
// An input word is folded into the window in the cycle it is accepted; its 0 to 2
// bytes go into a four-entry output queue, and one byte leaves the queue per cycle while m_axis_tready is high.
// s_axis_tready is high while the queue holds at most two bytes, so input words are
// taken in every cycle as long as the output drains; a sustained run of two-byte words
// is limited by the single output port.
// Reset clears the window, the fill count and the queue. Output stalls only back up
// through the queue occupancy.
`timescale 1ns / 1ps

module msb_first_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] data_bits, [20:16] bit_count, [23:21] zero
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);

  logic [mfbp_pkg::ByteW-1:0]  window_q, window_d;
  logic [mfbp_pkg::FillW-1:0]  fill_q, fill_d;

  mfbp_pkg::out_word_t          queue_q [mfbp_pkg::QueueDepth];
  logic [mfbp_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mfbp_pkg::QueueCntW-1:0] cnt_q;

  logic                           s_accept, m_accept;
  mfbp_pkg::req_e                 req;
  logic [mfbp_pkg::DataW-1:0]     data_in, data_m;
  logic [mfbp_pkg::CountW-1:0]    cnt_in, cnt_sat, total, shamt;
  logic [31:0]                    mask_w;
  logic [39:0]                    shifted;
  logic [mfbp_pkg::AccW-1:0]      acc;
  logic [1:0]                     n_push;
  mfbp_pkg::out_word_t            push0, push1;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  assign req     = mfbp_pkg::req_e'(s_axis_tuser);
  assign data_in = s_axis_tdata[15:0];
  assign cnt_in  = s_axis_tdata[20:16];

  always_comb begin
    if (cnt_in > mfbp_pkg::CountW'(mfbp_pkg::CountLimit)) begin
      cnt_sat = mfbp_pkg::CountW'(mfbp_pkg::CountLimit);
    end else begin
      cnt_sat = cnt_in;
    end
  end

  // New bits go right below the bits already held; the window sits at the top of acc.
  assign mask_w  = ~(32'hFFFF_FFFF << cnt_sat);
  assign data_m  = data_in & mask_w[mfbp_pkg::DataW-1:0];
  assign total   = {2'b00, fill_q} + cnt_sat;
  assign shamt   = 5'd24 - total;
  assign shifted = {24'd0, data_m} << shamt;
  assign acc     = shifted[mfbp_pkg::AccW-1:0] | {window_q, 16'd0};

  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    n_push   = 2'd0;
    push0    = '{last: 1'b0, data: acc[23:16]};
    push1    = '{last: 1'b0, data: acc[15:8]};
    case (req)
      mfbp_pkg::ReqFinish: begin
        push0    = '{last: 1'b0, data: window_q};
        push1    = '{last: 1'b1, data: {5'd0, fill_q}};
        n_push   = 2'd2;
        window_d = '0;
        fill_d   = '0;
      end
      mfbp_pkg::ReqAppend: begin
        n_push = total[4:3];
        fill_d = total[2:0];
        case (total[4:3])
          2'd0:    window_d = acc[23:16];
          2'd1:    window_d = acc[15:8];
          default: window_d = acc[7:0];
        endcase
      end
      default: begin
        n_push = 2'd0;
      end
    endcase
  end

  assign s_axis_tready = (cnt_q <= mfbp_pkg::QueueCntW'(2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = queue_q[rd_ptr_q].data;
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s_accept) begin
        window_q <= window_d;
        fill_q   <= fill_d;
        wr_ptr_q <= wr_ptr_q + mfbp_pkg::QueuePtrW'(n_push);
      end
      if (m_accept) begin
        rd_ptr_q <= rd_ptr_q + mfbp_pkg::QueuePtrW'(1);
      end
      cnt_q <= cnt_q + (s_accept ? {1'b0, n_push} : '0)
                     - (m_accept ? mfbp_pkg::QueueCntW'(1) : '0);
    end
  end

  // Queue payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_accept && (n_push != 2'd0)) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (s_accept && (n_push == 2'd2)) begin
      queue_q[wr_ptr_q + mfbp_pkg::QueuePtrW'(1)] <= push1;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mfbp_pkg::QueueCntW'(mfbp_pkg::QueueDepth))
    else $error("output queue overflow");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (req == mfbp_pkg::ReqFinish)) |=> (fill_q == '0 && window_q == '0))
    else $error("finish did not empty the window");

  a_window_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (window_q & (8'hFF >> fill_q)) == 8'h00)
    else $error("window holds bits below the fill point");

  a_trailer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:3] == 5'd0))
    else $error("trailer count out of range");
`endif

endmodule
